// ===== rtl/bst_pkg.sv =====
package bst_pkg;

    // Fixed field widths of the item and result channels.
    localparam int ELEM_W      = 6;
    localparam int SCORE_W     = 32;
    localparam int BETA_W      = 16;
    localparam int ACT_W       = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int SLOT_OUT_W  = 6;
    localparam int NCOUNT_W    = 6;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Outcome codes for one completed candidate.
    localparam logic [ACT_W-1:0] ACT_LOWER  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RESET  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DUP    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FULL   = 3'd4;

    // Register word index (paddr bit 2).
    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_COPY   = 4'b1000
    } state_t;

    // Compare command broadcast to every cell.
    typedef struct packed {
        logic              cmp_en;
        logic              first;
        logic [ELEM_W-1:0] elem;
    } cell_ctrl_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic found;
    } token_t;

endpackage

// ===== rtl/bst_ram.sv =====
module bst_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bst_cell.sv =====
module bst_cell
    import bst_pkg::*;
#(
    parameter int MAX_NODES = 32,
    parameter int SW        = 6,
    parameter int CNTW      = 7,
    parameter int K         = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctrl_t                   ctrl,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [ELEM_W-1:0]            wr_data,
    input  logic [CNTW-1:0]              count,
    input  token_t                       tok_in,
    input  logic [SW-1:0]                slot_in,
    output token_t                       tok_out,
    output logic [SW-1:0]                slot_out
);

    logic [ELEM_W-1:0] rd_data;
    logic              flag_reg;
    logic              flag_next;
    logic              active;
    token_t            tok_reg;
    token_t            tok_next;
    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     slot_next;

    // This cell's stored tree, one element per node.
    bst_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_NODES)
    ) u_tree (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign active = CNTW'(K) < count;

    always_comb
    begin
        flag_next = flag_reg;
        if (ctrl.cmp_en)
        begin
            flag_next = (ctrl.first | flag_reg) & (rd_data == ctrl.elem);
        end
    end

    // The first active matching cell claims the token; later cells pass it on.
    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found | (flag_reg & active);
        slot_next      = tok_in.found ? slot_in : SW'(K);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b1;
            tok_reg  <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule

// ===== rtl/best_score_tree_set_unit.sv =====
// Best-score tree set.
// Candidate trees arrive as parent vectors, one node element per item, on the
// start/busy channel: an item is taken at a clock edge where start is high and
// busy is low. node_count items form one candidate; only the score and best
// score of the final item of a candidate decide its fate; its beta is stored.
// Each completed candidate gives one result (action, entry_count, slot_index)
// marked by done for exactly one cycle. The receiver cannot stall, so results
// are simply presented and never held.
// Elements of a candidate are taken one per cycle while busy is low. After the
// final item busy rises; a lower or a new best score is decided and its result
// registered. An equal score sends a search token along the row of cells, one
// cell per cycle, and its result is registered when the token leaves the row.
// Storing a candidate copies the whole staging memory, all MAX_NODES elements,
// into its cell, one element per cycle, which keeps busy high until the last
// copy write. Staging positions not written since reset are copied as zero.
// The user must write node_count over the APB-style port only while the block
// is idle; the block itself does not enforce this. A write restarts the
// candidate at its first element.
// After reset the set is empty, node_count is 32 and the block is ready.
module best_score_tree_set_unit
    import bst_pkg::*;
#(
    parameter int MAX_TREES = 64,
    parameter int MAX_NODES = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [SCORE_W-1:0] score,
    input  logic signed [SCORE_W-1:0] best_score,
    input  logic [BETA_W-1:0]         beta,
    input  logic [ELEM_W-1:0]         parent_of_node,
    output logic                      done,
    output logic [ACT_W-1:0]          action,
    output logic [COUNT_OUT_W-1:0]    entry_count,
    output logic [SLOT_OUT_W-1:0]     slot_index
);

    localparam int PW   = $clog2(MAX_NODES);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int CW   = (NCW > NCOUNT_W) ? NCW : NCOUNT_W;
    localparam int SW   = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int CNTW = $clog2(MAX_TREES + 1);

    // Configuration and element position.
    logic [NCOUNT_W-1:0]       node_count_reg;
    logic [PW-1:0]             pos_reg;
    logic [PW-1:0]             pos_next;
    logic [CW-1:0]             nc_wide;
    logic [NCW-1:0]            n_eff;
    logic                      pos_last;
    logic                      cfg_we;
    logic                      accept;

    // Compare stage: the item taken in the previous cycle.
    logic                      cmp_valid_reg;
    logic                      cmp_first_reg;
    logic                      cmp_last_reg;
    logic [ELEM_W-1:0]         elem_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic [BETA_W-1:0]         beta_reg;

    // Control.
    state_t                    state_reg;
    state_t                    state_next;
    logic [CNTW-1:0]           count_reg;
    logic [CNTW-1:0]           count_next;
    logic [PW-1:0]             copy_addr_reg;
    logic [PW-1:0]             copy_addr_next;
    logic [SW-1:0]             copy_slot_reg;
    logic [SW-1:0]             copy_slot_next;
    logic                      copy_we_reg;
    logic [PW-1:0]             copy_waddr_reg;
    logic                      search_launch;
    logic                      store_go;
    logic [SW-1:0]             store_slot;

    // Result registers.
    logic                      done_reg;
    logic                      done_next;
    logic [ACT_W-1:0]          action_reg;
    logic [ACT_W-1:0]          action_next;
    logic [COUNT_OUT_W-1:0]    entry_count_reg;
    logic [COUNT_OUT_W-1:0]    entry_count_next;
    logic [SLOT_OUT_W-1:0]     slot_index_reg;
    logic [SLOT_OUT_W-1:0]     slot_index_next;

    // Datapath between memories and cells.
    logic [ELEM_W-1:0]         stage_rdata;
    logic [MAX_NODES-1:0]      stage_seen_reg;
    logic                      stage_seen_rd_reg;
    logic [ELEM_W-1:0]         stage_wdata;
    cell_ctrl_t                cell_ctrl;
    logic [MAX_TREES-1:0]      cell_we;
    token_t                    tok      [MAX_TREES + 1];
    logic [SW-1:0]             tok_slot [MAX_TREES + 1];

    // ------------------------------------------------------------------
    // Configuration port. Only bit 2 of paddr selects a register word.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_NODE_COUNT)
        begin
            prdata = APB_DATA_W'(node_count_reg);
        end
    end

    // A node count of zero behaves as one, and one above MAX_NODES is clamped.
    assign nc_wide = CW'(node_count_reg);

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NCW'(1);
        end
        else if (nc_wide > CW'(MAX_NODES))
        begin
            n_eff = NCW'(MAX_NODES);
        end
        else
        begin
            n_eff = NCW'(nc_wide);
        end
    end

    // ------------------------------------------------------------------
    // Item intake. busy also covers the cycle in which the final item of a
    // candidate sits in the compare stage, and the last copy write.
    // ------------------------------------------------------------------
    assign busy     = (state_reg != ST_IDLE) || (cmp_valid_reg && cmp_last_reg) || copy_we_reg;
    assign accept   = start && !busy;
    assign pos_last = (NCW'(pos_reg) + NCW'(1)) == n_eff;

    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_we)
        begin
            pos_next = '0;
        end
        else if (accept)
        begin
            pos_next = pos_last ? '0 : pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            pos_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= pwdata[NCOUNT_W-1:0];
            end
            pos_reg       <= pos_next;
            cmp_valid_reg <= accept;
            if (accept)
            begin
                cmp_last_reg <= pos_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmp_first_reg <= (pos_reg == '0);
            elem_reg      <= parent_of_node;
            score_reg     <= score;
            best_reg      <= best_score;
            beta_reg      <= beta;
        end
    end

    // The candidate in flight is staged here until its fate is known.
    bst_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_NODES)
    ) u_staging (
        .clk   (clk),
        .we    (accept),
        .waddr (pos_reg),
        .wdata (parent_of_node),
        .raddr (copy_addr_reg),
        .rdata (stage_rdata)
    );

    // One flag per staging position records whether it has been written since
    // reset; the flag is read alongside the memory so that the copy sees zero
    // for a position that has never been written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_seen_reg    <= '0;
            stage_seen_rd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_seen_reg[pos_reg] <= 1'b1;
            end
            stage_seen_rd_reg <= stage_seen_reg[copy_addr_reg];
        end
    end

    assign stage_wdata = stage_seen_rd_reg ? stage_rdata : '0;

    // Beta values kept alongside the stored trees.
    bst_ram #(
        .WIDTH (BETA_W),
        .DEPTH (MAX_TREES)
    ) u_beta (
        .clk   (clk),
        .we    (store_go),
        .waddr (store_slot),
        .wdata (beta_reg),
        .raddr (store_slot),
        .rdata ()
    );

    // ------------------------------------------------------------------
    // Row of cells. Every cell reads its element at the position of the item
    // being taken and compares it in the next cycle; the search token walks
    // the row one cell per cycle.
    // ------------------------------------------------------------------
    assign cell_ctrl.cmp_en = cmp_valid_reg;
    assign cell_ctrl.first  = cmp_first_reg;
    assign cell_ctrl.elem   = elem_reg;

    assign tok[0].valid = search_launch;
    assign tok[0].found = 1'b0;
    assign tok_slot[0]  = '0;

    for (genvar g = 0; g < MAX_TREES; g++)
    begin : g_cell
        assign cell_we[g] = copy_we_reg && (copy_slot_reg == SW'(g));

        bst_cell #(
            .MAX_NODES (MAX_NODES),
            .SW        (SW),
            .CNTW      (CNTW),
            .K         (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .rd_addr  (pos_reg),
            .wr_en    (cell_we[g]),
            .wr_addr  (copy_waddr_reg),
            .wr_data  (stage_wdata),
            .count    (count_reg),
            .tok_in   (tok[g]),
            .slot_in  (tok_slot[g]),
            .tok_out  (tok[g + 1]),
            .slot_out (tok_slot[g + 1])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer: decide, search, copy.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        copy_addr_next   = copy_addr_reg;
        copy_slot_next   = copy_slot_reg;
        search_launch    = 1'b0;
        store_go         = 1'b0;
        store_slot       = copy_slot_reg;
        done_next        = 1'b0;
        action_next      = action_reg;
        entry_count_next = entry_count_reg;
        slot_index_next  = slot_index_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmp_valid_reg && cmp_last_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (score_reg > best_reg)
                begin
                    // A new best score empties the set; the candidate takes slot zero.
                    store_go         = 1'b1;
                    store_slot       = '0;
                    count_next       = CNTW'(1);
                    done_next        = 1'b1;
                    action_next      = ACT_RESET;
                    entry_count_next = COUNT_OUT_W'(1);
                    slot_index_next  = '0;
                end
                else if (score_reg == best_reg)
                begin
                    search_launch = 1'b1;
                    state_next    = ST_SEARCH;
                end
                else
                begin
                    done_next        = 1'b1;
                    action_next      = ACT_LOWER;
                    entry_count_next = COUNT_OUT_W'(count_reg);
                    slot_index_next  = '0;
                    state_next       = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (tok[MAX_TREES].valid)
                begin
                    done_next = 1'b1;
                    if (tok[MAX_TREES].found)
                    begin
                        action_next      = ACT_DUP;
                        entry_count_next = COUNT_OUT_W'(count_reg);
                        slot_index_next  = SLOT_OUT_W'(tok_slot[MAX_TREES]);
                        state_next       = ST_IDLE;
                    end
                    else if (count_reg < CNTW'(MAX_TREES))
                    begin
                        store_go         = 1'b1;
                        store_slot       = SW'(count_reg);
                        count_next       = count_reg + CNTW'(1);
                        action_next      = ACT_APPEND;
                        entry_count_next = COUNT_OUT_W'(count_reg + CNTW'(1));
                        slot_index_next  = SLOT_OUT_W'(count_reg);
                    end
                    else
                    begin
                        action_next      = ACT_FULL;
                        entry_count_next = COUNT_OUT_W'(count_reg);
                        slot_index_next  = '0;
                        state_next       = ST_IDLE;
                    end
                end
            end
            ST_COPY:
            begin
                // Every staging position is copied, whatever node_count is.
                if (copy_addr_reg == PW'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    copy_addr_next = copy_addr_reg + PW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (store_go)
        begin
            copy_slot_next = store_slot;
            copy_addr_next = '0;
            state_next     = ST_COPY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            copy_we_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            copy_we_reg <= (state_reg == ST_COPY);
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg   <= copy_addr_next;
        copy_slot_reg   <= copy_slot_next;
        copy_waddr_reg  <= copy_addr_reg;
        action_reg      <= action_next;
        entry_count_reg <= entry_count_next;
        slot_index_reg  <= slot_index_next;
    end

    assign done        = done_reg;
    assign action      = action_reg;
    assign entry_count = entry_count_reg;
    assign slot_index  = slot_index_reg;

`ifndef NO_ASSERTIONS
    // No item may be taken while the last element of a copy is still landing.
    a_copy_busy: assert property (@(posedge clk) disable iff (!rst_n)
        copy_we_reg |-> busy)
        else $error("item accepted during a pending copy write");

    // The set never holds more trees than it has cells.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_TREES))
        else $error("entry count beyond the number of cells");

    // The token only leaves the row while the sequencer waits for it.
    a_token_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_TREES].valid |-> (state_reg == ST_SEARCH))
        else $error("search token left the row outside a search");

    // A decision always follows the final item of a candidate.
    a_decide_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> $past(cmp_valid_reg && cmp_last_reg))
        else $error("decision without a completed candidate");
`endif

endmodule
